// ----- rtl/core/all_pairs_shortest_path_assert.svh -----
// assertion helpers for the shortest path engine
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// condition holds in the same cycle
`define APSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/apsp_pkg.sv -----
package apsp_pkg;

   localparam int ACT_W  = 2;
   localparam int VTX_W  = 5;
   localparam int WGT_W  = 16;
   localparam int DIST_W = 20;
   localparam int VIA_W  = 5;
   localparam int OP_W   = 3;

   localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;

   localparam logic [DIST_W-1:0] INF_DIST = 20'd999999;

   // datapath operations, carried out in the cycle after the read is issued
   localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
   localparam logic [OP_W-1:0] OP_EDGE  = 3'd2;
   localparam logic [OP_W-1:0] OP_INF   = 3'd3;
   localparam logic [OP_W-1:0] OP_HOLD  = 3'd4;
   localparam logic [OP_W-1:0] OP_RELAX = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [WGT_W-1:0] weight;
   } dp_cmd_type;

endpackage

// ----- rtl/core/all_pairs_shortest_path.sv -----
// Floyd-Warshall shortest path engine for an undirected graph of up to VERTICES
// vertices, numbered from 1. A request is taken when start is high and busy is
// low; exactly one response follows, shown for a single cycle with rsp_valid
// high, and the receiver cannot hold it off. After reset the block clears both
// matrices, one entry per cycle over 2**(2*ceil(log2 VERTICES)) entries (256 at
// the default) with busy high. Insert reads the entry and rejects the request
// when it is already taken, else stores the edge both ways and then responds;
// query reads the entry and then responds; other action codes and out-of-range
// vertices are answered straight from idle. Compute first marks empty entries
// unreachable, then runs the relaxation: the distance memory does one
// read-add-compare-write per cycle, with a fetch of the row operand before
// each row.
module all_pairs_shortest_path import apsp_pkg::*; #(
   parameter int VERTICES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [VTX_W-1:0]  req_vertex_a,
   input  logic [VTX_W-1:0]  req_vertex_b,
   input  logic [WGT_W-1:0]  req_edge_weight,
   output logic              rsp_valid,
   output logic              rsp_accepted,
   output logic [DIST_W-1:0] rsp_distance,
   output logic [VIA_W-1:0]  rsp_via_vertex
);

   localparam int IW = $clog2(VERTICES);
   localparam int AW = 2 * IW;
   localparam int RW = $clog2(VERTICES + 1);

   dp_cmd_type        cmd;
   logic [AW-1:0]     addr_a;
   logic [AW-1:0]     addr_b;
   logic [RW-1:0]     route_val;
   logic [DIST_W-1:0] rd_dist;
   logic [RW-1:0]     rd_route;

   apsp_ctrl #(
      .VERTICES(VERTICES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .req_edge_weight(req_edge_weight),
      .rsp_valid      (rsp_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_distance   (rsp_distance),
      .rsp_via_vertex (rsp_via_vertex),
      .cmd            (cmd),
      .addr_a         (addr_a),
      .addr_b         (addr_b),
      .route_val      (route_val),
      .rd_dist        (rd_dist),
      .rd_route       (rd_route)
   );

   apsp_datapath #(
      .VERTICES(VERTICES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .addr_a   (addr_a),
      .addr_b   (addr_b),
      .route_val(route_val),
      .rd_dist  (rd_dist),
      .rd_route (rd_route)
   );

endmodule

// ----- rtl/core/apsp_datapath.sv -----
module apsp_datapath import apsp_pkg::*; #(
   parameter int VERTICES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dp_cmd_type                          cmd,
   input  logic [2*$clog2(VERTICES)-1:0]       addr_a,
   input  logic [2*$clog2(VERTICES)-1:0]       addr_b,
   input  logic [$clog2(VERTICES+1)-1:0]       route_val,
   output logic [DIST_W-1:0]                   rd_dist,
   output logic [$clog2(VERTICES+1)-1:0]       rd_route
);

   localparam int IW    = $clog2(VERTICES);
   localparam int AW    = 2 * IW;
   localparam int RW    = $clog2(VERTICES + 1);
   localparam int DEPTH = 1 << AW;

   logic [DIST_W-1:0] dist_mem  [DEPTH];
   logic [RW-1:0]     route_mem [DEPTH];

   logic [DIST_W-1:0] rda_ff;
   logic [DIST_W-1:0] rdb_ff;
   logic [RW-1:0]     rrb_ff;
   logic [DIST_W-1:0] hold_ff;
   logic [OP_W-1:0]   wop_ff;
   logic [AW-1:0]     waddr_ff;
   logic [RW-1:0]     wroute_ff;
   logic [WGT_W-1:0]  wweight_ff;

   logic [DIST_W:0]   sum;
   logic              better;
   logic              dist_we;
   logic              route_we;
   logic [DIST_W-1:0] dist_wdata;
   logic [RW-1:0]     route_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         wop_ff <= OP_NONE;
      end else begin
         wop_ff <= cmd.op;
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff   <= addr_b;
      wroute_ff  <= route_val;
      wweight_ff <= cmd.weight;
      // row operand d[i][k] stays fixed over the whole column sweep
      if (wop_ff == OP_HOLD) begin
         hold_ff <= rda_ff;
      end
   end

   always_ff @(posedge clock) begin
      rda_ff <= dist_mem[addr_a];
      rdb_ff <= dist_mem[addr_b];
      rrb_ff <= route_mem[addr_b];
      if (dist_we) begin
         dist_mem[waddr_ff] <= dist_wdata;
      end
      if (route_we) begin
         route_mem[waddr_ff] <= route_wdata;
      end
   end

   assign sum    = {1'b0, hold_ff} + {1'b0, rda_ff};
   assign better = sum < {1'b0, rdb_ff};

   always_comb begin
      dist_we     = 1'b0;
      route_we    = 1'b0;
      dist_wdata  = '0;
      route_wdata = '0;
      case (wop_ff)
         OP_CLEAR: begin
            dist_we  = 1'b1;
            route_we = 1'b1;
         end
         OP_EDGE: begin
            dist_we     = 1'b1;
            route_we    = 1'b1;
            dist_wdata  = DIST_W'(wweight_ff);
            route_wdata = wroute_ff;
         end
         OP_INF: begin
            dist_we    = rdb_ff == '0;
            dist_wdata = INF_DIST;
         end
         OP_RELAX: begin
            dist_we     = better;
            route_we    = better;
            dist_wdata  = sum[DIST_W-1:0];
            route_wdata = wroute_ff;
         end
         default: begin
            dist_we  = 1'b0;
            route_we = 1'b0;
         end
      endcase
   end

   assign rd_dist  = rdb_ff;
   assign rd_route = rrb_ff;

endmodule

// ----- rtl/core/apsp_ctrl.sv -----
module apsp_ctrl import apsp_pkg::*; #(
   parameter int VERTICES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ACT_W-1:0]                    req_action,
   input  logic [VTX_W-1:0]                    req_vertex_a,
   input  logic [VTX_W-1:0]                    req_vertex_b,
   input  logic [WGT_W-1:0]                    req_edge_weight,
   output logic                                rsp_valid,
   output logic                                rsp_accepted,
   output logic [DIST_W-1:0]                   rsp_distance,
   output logic [VIA_W-1:0]                    rsp_via_vertex,
   output dp_cmd_type                          cmd,
   output logic [2*$clog2(VERTICES)-1:0]       addr_a,
   output logic [2*$clog2(VERTICES)-1:0]       addr_b,
   output logic [$clog2(VERTICES+1)-1:0]       route_val,
   input  logic [DIST_W-1:0]                   rd_dist,
   input  logic [$clog2(VERTICES+1)-1:0]       rd_route
);

   localparam int IW = $clog2(VERTICES);
   localparam int AW = 2 * IW;
   localparam int RW = $clog2(VERTICES + 1);
   localparam logic [IW-1:0] LAST = IW'(VERTICES - 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_INS_RD   = 4'd2;
   localparam logic [3:0] S_INS_CHK  = 4'd3;
   localparam logic [3:0] S_INS_W2   = 4'd4;
   localparam logic [3:0] S_INS_DONE = 4'd5;
   localparam logic [3:0] S_Q_RD     = 4'd6;
   localparam logic [3:0] S_Q_DATA   = 4'd7;
   localparam logic [3:0] S_INIT     = 4'd8;
   localparam logic [3:0] S_ROW      = 4'd9;
   localparam logic [3:0] S_COL      = 4'd10;
   localparam logic [3:0] S_CDONE    = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [IW-1:0]     k_ff, k_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [IW-1:0]     j_ff, j_in;
   logic [IW-1:0]     va_ff, va_in;
   logic [IW-1:0]     vb_ff, vb_in;
   logic [WGT_W-1:0]  wgt_ff, wgt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [VIA_W-1:0]  rsp_via_ff, rsp_via_in;

   logic              a_ok;
   logic              b_ok;
   logic [IW-1:0]     a_idx;
   logic [IW-1:0]     b_idx;

   assign a_ok  = (req_vertex_a != '0) && (32'(req_vertex_a) <= 32'(VERTICES));
   assign b_ok  = (req_vertex_b != '0) && (32'(req_vertex_b) <= 32'(VERTICES));
   assign a_idx = IW'(32'(req_vertex_a) - 32'd1);
   assign b_idx = IW'(32'(req_vertex_b) - 32'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      wgt_ff      <= wgt_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_via_ff  <= rsp_via_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      wgt_in       = wgt_ff;
      rsp_valid_in = 1'b0;
      rsp_acc_in   = rsp_acc_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_via_in   = rsp_via_ff;
      cmd.op       = OP_NONE;
      cmd.weight   = wgt_ff;
      addr_a       = {va_ff, vb_ff};
      addr_b       = {va_ff, vb_ff};
      route_val    = RW'(vb_ff) + RW'(1);

      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            addr_b = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               va_in  = a_idx;
               vb_in  = b_idx;
               wgt_in = req_edge_weight;
               case (req_action)
                  ACT_INSERT: begin
                     if (a_ok && b_ok) begin
                        state_in = S_INS_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_acc_in   = 1'b0;
                        rsp_dist_in  = '0;
                        rsp_via_in   = '0;
                     end
                  end
                  ACT_COMPUTE: begin
                     k_in     = '0;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = S_INIT;
                  end
                  ACT_QUERY: begin
                     if (a_ok && b_ok) begin
                        state_in = S_Q_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_acc_in   = 1'b1;
                        rsp_dist_in  = '0;
                        rsp_via_in   = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_acc_in   = 1'b1;
                     rsp_dist_in  = '0;
                     rsp_via_in   = '0;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            // a nonzero distance means the entry is taken
            if (rd_dist != '0) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b0;
               rsp_dist_in  = '0;
               rsp_via_in   = '0;
               state_in     = S_IDLE;
            end else begin
               cmd.op   = OP_EDGE;
               state_in = S_INS_W2;
            end
         end
         S_INS_W2: begin
            cmd.op    = OP_EDGE;
            addr_b    = {vb_ff, va_ff};
            route_val = RW'(va_ff) + RW'(1);
            state_in  = S_INS_DONE;
         end
         S_INS_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_acc_in   = 1'b1;
            rsp_dist_in  = '0;
            rsp_via_in   = '0;
            state_in     = S_IDLE;
         end
         S_Q_RD: begin
            state_in = S_Q_DATA;
         end
         S_Q_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_acc_in   = 1'b1;
            rsp_dist_in  = rd_dist;
            rsp_via_in   = VIA_W'(rd_route);
            state_in     = S_IDLE;
         end
         S_INIT: begin
            // empty off-diagonal entries become unreachable
            addr_b = {i_ff, j_ff};
            cmd.op = (i_ff != j_ff) ? OP_INF : OP_NONE;
            j_in   = j_ff + IW'(1);
            if (j_ff == LAST) begin
               j_in = '0;
               i_in = i_ff + IW'(1);
               if (i_ff == LAST) begin
                  i_in     = '0;
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            addr_a   = {i_ff, k_ff};
            cmd.op   = OP_HOLD;
            j_in     = '0;
            state_in = S_COL;
         end
         S_COL: begin
            addr_a    = {k_ff, j_ff};
            addr_b    = {i_ff, j_ff};
            cmd.op    = OP_RELAX;
            route_val = RW'(k_ff) + RW'(1);
            j_in      = j_ff + IW'(1);
            if (j_ff == LAST) begin
               j_in     = '0;
               state_in = S_ROW;
               if (i_ff == LAST) begin
                  i_in = '0;
                  if (k_ff == LAST) begin
                     state_in = S_CDONE;
                  end else begin
                     k_in = k_ff + IW'(1);
                  end
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         S_CDONE: begin
            rsp_valid_in = 1'b1;
            rsp_acc_in   = 1'b1;
            rsp_dist_in  = '0;
            rsp_via_in   = '0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy           = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_distance   = rsp_dist_ff;
   assign rsp_via_vertex = rsp_via_ff;

endmodule

// ----- rtl/core/apsp_checker.sv -----
`include "all_pairs_shortest_path_assert.svh"

module apsp_checker import apsp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [ACT_W-1:0]  req_action,
   input logic [VTX_W-1:0]  req_vertex_a,
   input logic              rsp_valid,
   input logic [DIST_W-1:0] rsp_distance,
   input logic [VIA_W-1:0]  rsp_via_vertex
);

   logic req_take;
   logic compute_take;
   logic bad_query;
   logic empty_rsp;
   logic dist_ok;

   assign req_take     = start && !busy;
   assign compute_take = req_take && req_action == ACT_COMPUTE;
   assign bad_query    = req_take && req_action == ACT_QUERY && req_vertex_a == '0;
   assign empty_rsp    = rsp_valid && rsp_distance == '0 && rsp_via_vertex == '0;
   assign dist_ok      = rsp_distance <= INF_DIST;

   // responses only appear once the engine is back to idle
   `APSP_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "response while busy")

   `APSP_ASSERT_NEXT(a_compute_goes_busy, clock, reset, compute_take, busy, "compute not started")

   // a query with vertex zero answers at once with an empty entry
   `APSP_ASSERT_NEXT(a_bad_query_empty, clock, reset, bad_query, empty_rsp, "bad query not empty")

   `APSP_ASSERT_SAME(a_dist_range, clock, reset, rsp_valid, dist_ok, "distance above range")

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (.*);
